// ----- src/vfj_pkg.sv -----
package vfj_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DERIV_BITS  = SAMPLE_BITS + 2;
    localparam int MAX_COLS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_LIMIT   = 4096;
    localparam int ROW_W       = $clog2(ROW_LIMIT);
    localparam int ROWS_CFG_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

    localparam int NUM_LANES = 3;
    localparam int SLOT_W    = $clog2(NUM_LANES);
    localparam int LANE_UP   = 0;
    localparam int LANE_LEFT = 1;
    localparam int LANE_LAST = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] u;
        logic signed [SAMPLE_BITS-1:0] v;
    } vec_t;

    typedef struct packed {
        vec_t dx_hi;
        vec_t dx_lo;
        logic dx_one;
        vec_t dy_hi;
        vec_t dy_lo;
        logic dy_one;
    } lane_op_t;

    typedef struct packed {
        logic signed [DERIV_BITS-1:0] du_dx;
        logic signed [DERIV_BITS-1:0] du_dy;
        logic signed [DERIV_BITS-1:0] dv_dx;
        logic signed [DERIV_BITS-1:0] dv_dy;
    } deriv_t;

    typedef struct packed {
        deriv_t           d;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
    } jac_t;

endpackage

// ----- src/vfj_if.sv -----
interface vfj_in_if import vfj_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] u_sample;
    logic signed [SAMPLE_BITS-1:0] v_sample;

    modport source (output valid, output u_sample, output v_sample, input ready);
    modport sink (input valid, input u_sample, input v_sample, output ready);
endinterface

interface vfj_out_if import vfj_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DERIV_BITS-1:0] du_dx;
    logic signed [DERIV_BITS-1:0] du_dy;
    logic signed [DERIV_BITS-1:0] dv_dx;
    logic signed [DERIV_BITS-1:0] dv_dy;
    logic [ROW_W-1:0]             out_row;
    logic [COL_W-1:0]             out_col;
    logic                         last_of_run;
    logic                         frame_done;

    modport source (output valid, output du_dx, output du_dy, output dv_dx, output dv_dy,
                    output out_row, output out_col, output last_of_run, output frame_done,
                    input ready);
    modport sink (input valid, input du_dx, input du_dy, input dv_dx, input dv_dy,
                  input out_row, input out_col, input last_of_run, input frame_done,
                  output ready);
endinterface

// ----- src/vfj_line_buf.sv -----
module vfj_line_buf import vfj_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic             wr_bank,
    input  logic [COL_W-1:0] wr_addr,
    input  vec_t             wr_data,
    input  logic             rd_bank,
    input  logic [COL_W-1:0] rd_new_addr,
    input  logic [COL_W-1:0] rd_old_addr,
    output vec_t             q_new,
    output vec_t             q_old
);

    vec_t q_reg [2];
    vec_t byp_data_reg [2];
    logic byp_reg [2];
    vec_t word [2];
    logic rd_bank_reg;

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        vec_t             mem [MAX_COLS];
        logic [COL_W-1:0] rd_addr;
        logic             wr_here;

        assign rd_addr = (rd_bank == 1'(b)) ? rd_new_addr : rd_old_addr;
        assign wr_here = wr_en && (wr_bank == 1'(b));

        always_ff @(posedge clk)
        begin
            if (wr_here)
            begin
                mem[wr_addr] <= wr_data;
            end
            q_reg[b]        <= mem[rd_addr];
            byp_data_reg[b] <= wr_data;
        end

        // A read of the word being written this cycle takes the new data.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                byp_reg[b] <= 1'b0;
            end
            else
            begin
                byp_reg[b] <= wr_here && (wr_addr == rd_addr);
            end
        end

        assign word[b] = byp_reg[b] ? byp_data_reg[b] : q_reg[b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_bank_reg <= 1'b0;
        end
        else
        begin
            rd_bank_reg <= rd_bank;
        end
    end

    assign q_new = word[rd_bank_reg];
    assign q_old = word[~rd_bank_reg];

endmodule

// ----- src/vfj_lane.sv -----
module vfj_lane import vfj_pkg::*; (
    input  lane_op_t op,
    output deriv_t   d
);

    function automatic logic signed [DERIV_BITS-1:0] diff(
        input logic signed [SAMPLE_BITS-1:0] hi,
        input logic signed [SAMPLE_BITS-1:0] lo,
        input logic                          one
    );
        logic signed [SAMPLE_BITS:0] t;
        t = $signed({hi[SAMPLE_BITS-1], hi}) - $signed({lo[SAMPLE_BITS-1], lo});
        return one ? {t, 1'b0} : {t[SAMPLE_BITS], t};
    endfunction

    assign d.du_dx = diff(op.dx_hi.u, op.dx_lo.u, op.dx_one);
    assign d.dv_dx = diff(op.dx_hi.v, op.dx_lo.v, op.dx_one);
    assign d.du_dy = diff(op.dy_hi.u, op.dy_lo.u, op.dy_one);
    assign d.dv_dy = diff(op.dy_hi.v, op.dy_lo.v, op.dy_one);

endmodule

// ----- src/vfj_merge.sv -----
module vfj_merge import vfj_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jac_t              res [NUM_LANES],
    input  logic [SLOT_W-1:0] last_slot,
    output logic              take,
    vfj_out_if.source         jac_out
);

    jac_t              buf_reg [NUM_LANES];
    logic              valid_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] last_reg;
    logic              fire;
    logic              drain;
    jac_t              slot;

    assign fire  = valid_reg && jac_out.ready;
    assign drain = fire && (idx_reg == last_reg);
    assign take  = !valid_reg || drain;

    always_ff @(posedge clk)
    begin
        if (load && take)
        begin
            buf_reg  <= res;
            last_reg <= last_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load && take)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (drain)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign slot                = buf_reg[idx_reg];
    assign jac_out.valid       = valid_reg;
    assign jac_out.du_dx       = slot.d.du_dx;
    assign jac_out.du_dy       = slot.d.du_dy;
    assign jac_out.dv_dx       = slot.d.dv_dx;
    assign jac_out.dv_dy       = slot.d.dv_dy;
    assign jac_out.out_row     = slot.row;
    assign jac_out.out_col     = slot.col;
    assign jac_out.frame_done  = slot.done;
    assign jac_out.last_of_run = (idx_reg == last_reg);

endmodule

// ----- src/vector_field_jacobian_2d.sv -----
// Channel    Direction  Payload
// pix_in     sink       u_sample, v_sample
// jac_out    source     du_dx, du_dy, dv_dx, dv_dy, out_row, out_col, last_of_run,
//                       frame_done
// cfg        write      cfg_we, cfg_index, cfg_data
//
// One vector is taken per cycle while the output buffer can take its results.
// Row zero gives no results and the other rows before the last give one result per
// vector, so the rate is one per cycle while jac_out is ready.
// In the last row a vector past column zero gives two or three results, and the
// single output port holds the input until all of them are sent.
// Reset and any configuration write restart the frame at row zero, column zero.
module vector_field_jacobian_2d import vfj_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vfj_in_if.sink                pix_in,
    vfj_out_if.source             jac_out
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             bank_reg, bank_next;
    logic [ROW_W-1:0] rows_last_reg;
    logic [COL_W-1:0] cols_last_reg;
    vec_t             rp0_reg, rp1_reg, first_reg, nb_prev_reg, nb_cur_reg;

    logic                  take, accept, at_last_col, at_last_row;
    vec_t                  cur, q_new, q_old;
    logic [ROWS_CFG_W-1:0] rows_in;
    logic [COLS_CFG_W-1:0] cols_in;
    lane_op_t              ops [NUM_LANES];
    deriv_t                dv [NUM_LANES];
    jac_t                  res [NUM_LANES];
    logic [SLOT_W-1:0]     last_slot;

    assign accept      = pix_in.valid && take;
    assign pix_in.ready = take;
    assign cur         = '{u: pix_in.u_sample, v: pix_in.v_sample};
    assign at_last_col = (col_reg == cols_last_reg);
    assign at_last_row = (row_reg == rows_last_reg);
    assign rows_in     = cfg_data[ROWS_CFG_W-1:0];
    assign cols_in     = cfg_data[COLS_CFG_W-1:0];

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_next  = '0;
                row_next  = at_last_row ? '0 : row_reg + 1'b1;
                bank_next = ~bank_reg;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            bank_reg      <= 1'b0;
            rows_last_reg <= ROW_W'(1);
            cols_last_reg <= COL_W'(1);
            rp0_reg       <= '0;
            rp1_reg       <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            bank_reg <= bank_next;
            if (cfg_we)
            begin
                rp0_reg <= '0;
                rp1_reg <= '0;
                case (cfg_index)
                    REG_FRAME_ROWS:
                    begin
                        if (rows_in < ROWS_CFG_W'(2))
                        begin
                            rows_last_reg <= ROW_W'(1);
                        end
                        else if (rows_in > ROWS_CFG_W'(ROW_LIMIT))
                        begin
                            rows_last_reg <= ROW_W'(ROW_LIMIT - 1);
                        end
                        else
                        begin
                            rows_last_reg <= ROW_W'(rows_in - 1'b1);
                        end
                    end
                    REG_FRAME_COLS:
                    begin
                        if (cols_in < COLS_CFG_W'(2))
                        begin
                            cols_last_reg <= COL_W'(1);
                        end
                        else if (cols_in > COLS_CFG_W'(MAX_COLS))
                        begin
                            cols_last_reg <= COL_W'(MAX_COLS - 1);
                        end
                        else
                        begin
                            cols_last_reg <= COL_W'(cols_in - 1'b1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                rp1_reg <= rp0_reg;
                rp0_reg <= cur;
            end
        end
    end

    // Window over the previous row: nb_prev is column c-1, nb_cur column c, and the
    // buffer read data is column c+1.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (col_reg == '0)
            begin
                first_reg <= cur;
            end
            nb_prev_reg <= nb_cur_reg;
            nb_cur_reg  <= at_last_col ? first_reg : q_new;
        end
    end

    vfj_line_buf u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept),
        .wr_bank    (~bank_reg),
        .wr_addr    (col_reg),
        .wr_data    (cur),
        .rd_bank    (bank_next),
        .rd_new_addr(col_next + 1'b1),
        .rd_old_addr(col_next),
        .q_new      (q_new),
        .q_old      (q_old)
    );

    always_comb
    begin
        // Location above the current one.
        ops[LANE_UP].dx_one = 1'b1;
        if (col_reg == '0)
        begin
            ops[LANE_UP].dx_hi = q_new;
            ops[LANE_UP].dx_lo = nb_cur_reg;
        end
        else if (at_last_col)
        begin
            ops[LANE_UP].dx_hi = nb_cur_reg;
            ops[LANE_UP].dx_lo = nb_prev_reg;
        end
        else
        begin
            ops[LANE_UP].dx_hi  = q_new;
            ops[LANE_UP].dx_lo  = nb_prev_reg;
            ops[LANE_UP].dx_one = 1'b0;
        end
        ops[LANE_UP].dy_hi  = cur;
        ops[LANE_UP].dy_one = (row_reg == ROW_W'(1));
        ops[LANE_UP].dy_lo  = (row_reg == ROW_W'(1)) ? nb_cur_reg : q_old;

        // Last row, location to the left.
        ops[LANE_LEFT].dx_hi  = cur;
        ops[LANE_LEFT].dx_one = (col_reg == COL_W'(1));
        ops[LANE_LEFT].dx_lo  = (col_reg == COL_W'(1)) ? rp0_reg : rp1_reg;
        ops[LANE_LEFT].dy_hi  = rp0_reg;
        ops[LANE_LEFT].dy_lo  = nb_prev_reg;
        ops[LANE_LEFT].dy_one = 1'b1;

        // Last row, current location at the final column.
        ops[LANE_LAST].dx_hi  = cur;
        ops[LANE_LAST].dx_lo  = rp0_reg;
        ops[LANE_LAST].dx_one = 1'b1;
        ops[LANE_LAST].dy_hi  = cur;
        ops[LANE_LAST].dy_lo  = nb_cur_reg;
        ops[LANE_LAST].dy_one = 1'b1;
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        vfj_lane u_lane (
            .op(ops[i]),
            .d (dv[i])
        );
    end

    assign res[LANE_UP]   = '{d: dv[LANE_UP], row: row_reg - 1'b1, col: col_reg, done: 1'b0};
    assign res[LANE_LEFT] = '{d: dv[LANE_LEFT], row: row_reg, col: col_reg - 1'b1,
                              done: 1'b0};
    assign res[LANE_LAST] = '{d: dv[LANE_LAST], row: row_reg, col: col_reg, done: 1'b1};

    always_comb
    begin
        if (at_last_row && (col_reg != '0))
        begin
            last_slot = at_last_col ? SLOT_W'(LANE_LAST) : SLOT_W'(LANE_LEFT);
        end
        else
        begin
            last_slot = SLOT_W'(LANE_UP);
        end
    end

    vfj_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && (row_reg != '0)),
        .res      (res),
        .last_slot(last_slot),
        .take     (take),
        .jac_out  (jac_out)
    );

endmodule

// ----- src/vfj_checker.sv -----
module vfj_checker import vfj_pkg::*; (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         last_of_run,
    input logic                         frame_done,
    input logic [ROW_W-1:0]             out_row,
    input logic [COL_W-1:0]             out_col,
    input logic signed [DERIV_BITS-1:0] du_dx
);

    // The input is held back only while results are waiting.
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // A transfer that does not end its run is followed by another result.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("run of results broken off");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame end is not the last result of its run");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(du_dx))
        else $error("stalled result changed");

endmodule

bind vector_field_jacobian_2d vfj_checker u_vfj_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .out_valid  (jac_out.valid),
    .out_ready  (jac_out.ready),
    .last_of_run(jac_out.last_of_run),
    .frame_done (jac_out.frame_done),
    .out_row    (jac_out.out_row),
    .out_col    (jac_out.out_col),
    .du_dx      (jac_out.du_dx)
);

// ----- tb/tb_vector_field_jacobian_2d.sv -----
module tb_vector_field_jacobian_2d import vfj_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        deriv_t           d;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             done;
    } jac_expect_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vfj_in_if  pix_in ();
    vfj_out_if jac_out ();

    vector_field_jacobian_2d u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .jac_out   (jac_out)
    );

    vec_t                  line_mem [2][MAX_COLS];
    bit                    newer_sel;
    vec_t                  recent_pix [2];
    int                    row_at;
    int                    col_at;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    jac_expect_t           pending_jacobians [$];
    int                    mismatches;
    int                    burst_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_rows();
        int r;
        r = int'(rows_reg);
        if (r < 2)
            r = 2;
        if (r > ROW_LIMIT)
            r = ROW_LIMIT;
        return r;
    endfunction

    function automatic int active_cols();
        int c;
        c = int'(cols_reg);
        if (c < 2)
            c = 2;
        if (c > MAX_COLS)
            c = MAX_COLS;
        return c;
    endfunction

    // A one-sided difference counts twice, so every slope is in half-LSB units.
    function automatic logic signed [DERIV_BITS-1:0] slope(logic signed [SAMPLE_BITS-1:0] hi,
                                                          logic signed [SAMPLE_BITS-1:0] lo,
                                                          bit one_sided);
        int d;
        d = int'(hi) - int'(lo);
        if (one_sided)
            d = 2 * d;
        return d[DERIV_BITS-1:0];
    endfunction

    function automatic jac_expect_t jacobian(vec_t dx_hi, vec_t dx_lo, bit dx_one,
                                             vec_t dy_hi, vec_t dy_lo, bit dy_one,
                                             int row, int col, bit done);
        jac_expect_t j;
        j.d.du_dx = slope(dx_hi.u, dx_lo.u, dx_one);
        j.d.dv_dx = slope(dx_hi.v, dx_lo.v, dx_one);
        j.d.du_dy = slope(dy_hi.u, dy_lo.u, dy_one);
        j.d.dv_dy = slope(dy_hi.v, dy_lo.v, dy_one);
        j.row     = row[ROW_W-1:0];
        j.col     = col[COL_W-1:0];
        j.last    = 1'b0;
        j.done    = done;
        return j;
    endfunction

    task automatic predict_jacobians(vec_t cur);
        int          rows;
        int          cols;
        int          r;
        int          c;
        int          n;
        int          i;
        bit          nb;
        bit          ob;
        jac_expect_t run [3];
        vec_t        dx_hi;
        vec_t        dx_lo;
        vec_t        dy_hi;
        vec_t        dy_lo;
        bit          dx_one;
        bit          dy_one;
        rows = active_rows();
        cols = active_cols();
        r    = row_at;
        c    = col_at;
        n    = 0;
        nb   = newer_sel;
        ob   = !newer_sel;
        if (r >= 1)
        begin
            if (c == 0)
            begin
                dx_hi  = line_mem[nb][1];
                dx_lo  = line_mem[nb][0];
                dx_one = 1'b1;
            end
            else if (c == cols - 1)
            begin
                dx_hi  = line_mem[nb][c];
                dx_lo  = line_mem[nb][c-1];
                dx_one = 1'b1;
            end
            else
            begin
                dx_hi  = line_mem[nb][c+1];
                dx_lo  = line_mem[nb][c-1];
                dx_one = 1'b0;
            end
            dy_hi = cur;
            if (r == 1)
            begin
                dy_lo  = line_mem[nb][c];
                dy_one = 1'b1;
            end
            else
            begin
                dy_lo  = line_mem[ob][c];
                dy_one = 1'b0;
            end
            run[n] = jacobian(dx_hi, dx_lo, dx_one, dy_hi, dy_lo, dy_one, r - 1, c, 1'b0);
            n++;
            // The last row is emitted as it arrives, one location behind.
            if (r == rows - 1 && c >= 1)
            begin
                run[n] = jacobian(cur, (c == 1) ? recent_pix[0] : recent_pix[1], c == 1,
                                  recent_pix[0], line_mem[nb][c-1], 1'b1, r, c - 1, 1'b0);
                n++;
                if (c == cols - 1)
                begin
                    run[n] = jacobian(cur, recent_pix[0], 1'b1, cur, line_mem[nb][c], 1'b1,
                                      r, c, 1'b1);
                    n++;
                end
            end
            run[n-1].last = 1'b1;
            for (i = 0; i < n; i++)
                pending_jacobians.push_back(run[i]);
        end
        line_mem[ob][c] = cur;
        recent_pix[1]   = recent_pix[0];
        recent_pix[0]   = cur;
        if (c + 1 >= cols)
        begin
            newer_sel = !newer_sel;
            col_at    = 0;
            row_at    = (r + 1 >= rows) ? 0 : r + 1;
        end
        else
            col_at = c + 1;
    endtask

    task automatic report_mismatch(string field, int got, int want, int row, int col);
        mismatches++;
        if (mismatches <= 30)
            $display("%0t: mismatch on %s at (%0d,%0d): got %0d, expected %0d",
                     $realtime, field, row, col, got, want);
    endtask

    always @(posedge clk)
    begin
        jac_expect_t want;
        int          wr;
        int          wc;
        if (rst_n && jac_out.valid && jac_out.ready)
        begin
            if (pending_jacobians.size() == 0)
                report_mismatch("transfer with nothing expected", 1, 0,
                                int'(jac_out.out_row), int'(jac_out.out_col));
            else
            begin
                want = pending_jacobians.pop_front();
                wr   = int'(want.row);
                wc   = int'(want.col);
                if (jac_out.du_dx !== want.d.du_dx)
                    report_mismatch("du_dx", int'(jac_out.du_dx), int'(want.d.du_dx), wr, wc);
                if (jac_out.du_dy !== want.d.du_dy)
                    report_mismatch("du_dy", int'(jac_out.du_dy), int'(want.d.du_dy), wr, wc);
                if (jac_out.dv_dx !== want.d.dv_dx)
                    report_mismatch("dv_dx", int'(jac_out.dv_dx), int'(want.d.dv_dx), wr, wc);
                if (jac_out.dv_dy !== want.d.dv_dy)
                    report_mismatch("dv_dy", int'(jac_out.dv_dy), int'(want.d.dv_dy), wr, wc);
                if (jac_out.out_row !== want.row)
                    report_mismatch("out_row", int'(jac_out.out_row), wr, wr, wc);
                if (jac_out.out_col !== want.col)
                    report_mismatch("out_col", int'(jac_out.out_col), wc, wr, wc);
                if (jac_out.last_of_run !== want.last)
                    report_mismatch("last_of_run", int'(jac_out.last_of_run), int'(want.last),
                                    wr, wc);
                if (jac_out.frame_done !== want.done)
                    report_mismatch("frame_done", int'(jac_out.frame_done), int'(want.done),
                                    wr, wc);
            end
        end
    end

    initial
    begin
        int mode;
        int span;
        jac_out.ready = 1'b0;
        mode          = 0;
        span          = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(4, 60);
            end
            span--;
            case (mode)
                0:       jac_out.ready <= 1'b1;
                1:       jac_out.ready <= ($urandom_range(0, 3) != 0);
                default: jac_out.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_BITS'($urandom_range(0, 15) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_jacobians.size() != 0);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        // Row zero transfers leave nothing to wait for, so give the pipeline time to empty.
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_FRAME_ROWS)
            rows_reg = value;
        else
            cols_reg = value[COLS_CFG_W-1:0];
        row_at        = 0;
        col_at        = 0;
        recent_pix[0] = '0;
        recent_pix[1] = '0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic signed [SAMPLE_BITS-1:0] u, logic signed [SAMPLE_BITS-1:0] v);
        vec_t cur;
        if (burst_left <= 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 16);
        end
        cur.u = u;
        cur.v = v;
        pix_in.valid    <= 1'b1;
        pix_in.u_sample <= u;
        pix_in.v_sample <= v;
        do
            @(posedge clk);
        while (!pix_in.ready);
        predict_jacobians(cur);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic test_reset_geometry();
        send_pixel(16'sh7FFF, 16'sh8000);
        send_pixel(16'sh8000, 16'sh7FFF);
        send_pixel(16'sh8000, 16'sh7FFF);
        send_pixel(16'sh7FFF, 16'sh8000);
        send_pixel(16'sh0000, -16'sd1);
        send_pixel(-16'sd1, 16'sh0000);
        send_pixel(16'sd1, -16'sd2);
        send_pixel(16'sh0000, 16'sh0000);
    endtask

    task automatic test_interior_3x3();
        int i;
        program_reg(REG_FRAME_ROWS, 13'd3);
        program_reg(REG_FRAME_COLS, 13'd3);
        for (i = 0; i < 9; i++)
            send_pixel(((i % 3 == 2) ^ (i / 3 == 1)) ? 16'sh7FFF : 16'sh8000,
                       (i / 3 == 2) ? 16'sh7FFF : 16'sh8000);
    endtask

    task automatic test_geometry_clamp();
        int i;
        program_reg(REG_FRAME_ROWS, 13'd0);
        program_reg(REG_FRAME_COLS, 13'h1801);
        for (i = 0; i < 4; i++)
            send_pixel(rand_sample(), rand_sample());
    endtask

    task automatic test_random_frames();
        int sent;
        int rows;
        int cols;
        int n;
        int i;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < 300)
        begin
            rows = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : $urandom_range(2, 4);
            cols = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 6);
            program_reg(REG_FRAME_ROWS, CFG_DATA_W'(rows));
            program_reg(REG_FRAME_COLS, CFG_DATA_W'(cols));
            n = $urandom_range(1, 3) * rows * cols;
            // Now and then the frame is cut short and restarted by the next register write.
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            if (n > 300 - sent)
                n = 300 - sent;
            for (i = 0; i < n; i++)
            begin
                if ((!paused && i == n / 2 && sent > 40) || $urandom_range(0, 63) == 0)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_pixel(rand_sample(), rand_sample());
                sent++;
            end
        end
    endtask

    task automatic test_wide_frame();
        int i;
        program_reg(REG_FRAME_ROWS, 13'd2);
        program_reg(REG_FRAME_COLS, 13'h1FFF);
        for (i = 0; i < 20; i++)
            send_pixel(rand_sample(), rand_sample());
    endtask

    task automatic test_tall_frame();
        int i;
        program_reg(REG_FRAME_ROWS, 13'h1FFF);
        program_reg(REG_FRAME_COLS, 13'd2);
        for (i = 0; i < 24; i++)
            send_pixel(rand_sample(), rand_sample());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_FRAME_ROWS;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.u_sample = '0;
        pix_in.v_sample = '0;
        mismatches      = 0;
        burst_left      = 0;
        rows_reg        = 2;
        cols_reg        = 2;
        row_at          = 0;
        col_at          = 0;
        newer_sel       = 1'b0;
        recent_pix[0]   = '0;
        recent_pix[1]   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_geometry();
        test_interior_3x3();
        test_geometry_clamp();
        test_random_frames();
        test_wide_frame();
        test_tall_frame();
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("tb_vector_field_jacobian_2d: PASS");
        else
            $display("tb_vector_field_jacobian_2d: FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_vector_field_jacobian_2d: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/vfj_pkg.sv
src/vfj_if.sv
src/vfj_line_buf.sv
src/vfj_lane.sv
src/vfj_merge.sv
src/vector_field_jacobian_2d.sv
src/vfj_checker.sv
tb/tb_vector_field_jacobian_2d.sv
